// File: hdl/sfa_pkg.sv
// shared types, constants and crc function for the stun fingerprint appender
// no dependencies
package sfa_pkg;

	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] FP_MASK   = 32'h5354_554E;
	localparam logic [15:0] ATTR_TYPE = 16'h8028;
	localparam logic [15:0] ATTR_LEN  = 16'h0004;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int ATTR_BYTES  = 8;
	localparam int PHASE_W     = $clog2(ATTR_BYTES + 1);

	localparam logic [PHASE_W-1:0] PH_PASS      = '0;
	localparam logic [PHASE_W-1:0] PH_TYPE_HI   = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_TYPE_LO   = PHASE_W'(2);
	localparam logic [PHASE_W-1:0] PH_LEN_HI    = PHASE_W'(3);
	localparam logic [PHASE_W-1:0] PH_LEN_LO    = PHASE_W'(4);
	localparam logic [PHASE_W-1:0] PH_FP_3      = PHASE_W'(5);
	localparam logic [PHASE_W-1:0] PH_FP_2      = PHASE_W'(6);
	localparam logic [PHASE_W-1:0] PH_FP_1      = PHASE_W'(7);
	localparam logic [PHASE_W-1:0] PH_FP_0      = PHASE_W'(ATTR_BYTES);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_final;
	} pkt_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_final;
		logic [31:0] fp;
	} entry_t;

	function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/stun_fingerprint_appender.sv
// Streams a STUN message through one byte per cycle while neither side stalls, and
// appends the 8-byte FINGERPRINT attribute (type 0x8028, length 4, crc32 xor
// 0x5354554E) after the byte marked is_final. While the back end's byte serializer
// emits a final byte and its attribute, the front keeps taking bytes until the
// 4-entry queue fills. A passed byte is registered in the queue and then in the back
// end's current-entry register before it is offered on the output. The crc restarts
// after every fingerprint.
// depends on sfa_pkg, sfa_front, sfa_queue, sfa_back
module stun_fingerprint_appender (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	input  sfa_pkg::msg_t msg,
	output logic          msg_stall,
	output logic          pkt_valid,
	output sfa_pkg::pkt_t pkt,
	input  logic          pkt_stall
);
	import sfa_pkg::*;

	logic   push;
	logic   pop;
	logic   full;
	logic   nonempty;
	entry_t push_entry;
	entry_t head;

	sfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg        (msg),
		.msg_stall  (msg_stall),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	sfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.nonempty   (nonempty),
		.full       (full)
	);

	sfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.nonempty  (nonempty),
		.pop       (pop),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.pkt_stall (pkt_stall)
	);

endmodule

// File: hdl/sfa_front.sv
// front end: accepts message bytes, runs the crc, builds queue entries
// depends on sfa_pkg
module sfa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            msg_valid,
	input  sfa_pkg::msg_t   msg,
	output logic            msg_stall,
	input  logic            full,
	output logic            push,
	output sfa_pkg::entry_t push_entry
);
	import sfa_pkg::*;

	logic [31:0] crc_q;
	logic [31:0] crc_next;

	assign msg_stall = full;
	assign push      = msg_valid & ~full;
	assign crc_next  = crc_fold_byte(crc_q, msg.data_byte);

	always_comb begin
		push_entry.data_byte = msg.data_byte;
		push_entry.is_final  = msg.is_final;
		push_entry.fp        = crc_next ^ CRC_INIT ^ FP_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (push) begin
			crc_q <= msg.is_final ? CRC_INIT : crc_next;
		end
	end

endmodule

// File: hdl/sfa_queue.sv
// short fifo between front and back ends
// depends on sfa_pkg
module sfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfa_pkg::entry_t push_entry,
	input  logic            pop,
	output sfa_pkg::entry_t head,
	output logic            nonempty,
	output logic            full
);
	import sfa_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign full     = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/sfa_back.sv
// back end: emits the passed byte and, after a final byte, the attribute bytes
// depends on sfa_pkg
module sfa_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sfa_pkg::entry_t head,
	input  logic            nonempty,
	output logic            pop,
	output logic            pkt_valid,
	output sfa_pkg::pkt_t   pkt,
	input  logic            pkt_stall
);
	import sfa_pkg::*;

	entry_t             cur_q;
	logic               busy_q;
	logic [PHASE_W-1:0] phase_q;
	logic               advance;
	logic               done;

	assign pkt_valid = busy_q;
	assign advance   = busy_q & ~pkt_stall;
	assign done      = advance & (((phase_q == PH_PASS) & ~cur_q.is_final) | (phase_q == PH_FP_0));
	assign pop       = nonempty & (~busy_q | done);

	always_comb begin
		pkt.out_final = (phase_q == PH_FP_0);
		case (phase_q)
			PH_PASS:    pkt.out_byte = cur_q.data_byte;
			PH_TYPE_HI: pkt.out_byte = ATTR_TYPE[15:8];
			PH_TYPE_LO: pkt.out_byte = ATTR_TYPE[7:0];
			PH_LEN_HI:  pkt.out_byte = ATTR_LEN[15:8];
			PH_LEN_LO:  pkt.out_byte = ATTR_LEN[7:0];
			PH_FP_3:    pkt.out_byte = cur_q.fp[31:24];
			PH_FP_2:    pkt.out_byte = cur_q.fp[23:16];
			PH_FP_1:    pkt.out_byte = cur_q.fp[15:8];
			PH_FP_0:    pkt.out_byte = cur_q.fp[7:0];
			default:    pkt.out_byte = cur_q.data_byte;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_PASS;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= PH_PASS;
		end else if (done) begin
			busy_q  <= 1'b0;
			phase_q <= PH_PASS;
		end else if (advance) begin
			phase_q <= phase_q + 1'b1;
		end
	end

endmodule

// File: hdl/sfa_checker.sv
// port-level checks for the stun fingerprint appender, bound to the top level
// depends on sfa_pkg and stun_fingerprint_appender
module sfa_assert (
	input logic          clk,
	input logic          arst_n,
	input logic          msg_valid,
	input sfa_pkg::msg_t msg,
	input logic          msg_stall,
	input logic          pkt_valid,
	input sfa_pkg::pkt_t pkt,
	input logic          pkt_stall
);
	import sfa_pkg::*;

	localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

	logic [PEND_W-1:0] pend_q;
	logic              fin_in;
	logic              fin_out;

	assign fin_in  = msg_valid & ~msg_stall & msg.is_final;
	assign fin_out = pkt_valid & ~pkt_stall & pkt.out_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (fin_in && !fin_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (fin_out && !fin_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt))
		else $error("output transaction changed while stalled");

	// fingerprint end only after a final byte came in
	a_fin_src: assert property (@(posedge clk) disable iff (!arst_n)
		fin_out |-> pend_q != '0)
		else $error("fingerprint end without a final input byte");

	// open messages bounded by queue plus back end
	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(QUEUE_DEPTH + 1))
		else $error("too many open fingerprints");

	// input stalls only while output has work
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_stall |-> pkt_valid)
		else $error("input stalled with idle output");

endmodule

bind stun_fingerprint_appender sfa_assert u_sfa_assert (.*);

// File: test/sfa_checker.sv
// checker for the stun fingerprint appender: watches both channels, predicts the output
// bytes, with the fingerprint attribute after each final byte, compares in order
// depends on sfa_pkg
`timescale 1ns / 100ps

module sfa_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	input  sfa_pkg::msg_t msg,
	input  logic          msg_stall,
	input  logic          pkt_valid,
	input  sfa_pkg::pkt_t pkt,
	input  logic          pkt_stall,
	output int            mismatches,
	output int            outstanding
);
	import sfa_pkg::*;

	logic [31:0] crc_acc;
	pkt_t        expected_pkts[$];
	int          mismatch_cnt;

	// reflected crc, one message bit per step
	function automatic logic [31:0] crc_update(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ ({32{r[0] ^ b[k]}} & CRC_POLY);
		end
		return r;
	endfunction

	function automatic pkt_t make_pkt(input logic [7:0] b, input logic fin);
		pkt_t p;
		p.out_byte  = b;
		p.out_final = fin;
		return p;
	endfunction

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		mismatch_cnt = 0;
		crc_acc      = CRC_INIT;
	end

	always @(posedge clk or negedge arst_n) begin
		pkt_t        want;
		logic [31:0] fp;
		logic [63:0] attr;
		if (!arst_n) begin
			crc_acc = CRC_INIT;
			expected_pkts.delete();
		end else begin
			if (pkt_valid && !pkt_stall) begin
				if (expected_pkts.size() == 0) begin
					$display("%0t: unexpected output transaction: actual %h/%b", $time,
						pkt.out_byte, pkt.out_final);
					mismatch_cnt++;
				end else begin
					want = expected_pkts.pop_front();
					if (pkt.out_byte !== want.out_byte || pkt.out_final !== want.out_final) begin
						$display("%0t: output mismatch: expected %h/%b actual %h/%b", $time,
							want.out_byte, want.out_final, pkt.out_byte, pkt.out_final);
						mismatch_cnt++;
					end
				end
			end
			if (msg_valid && !msg_stall) begin
				crc_acc = crc_update(crc_acc, msg.data_byte);
				expected_pkts.push_back(make_pkt(msg.data_byte, 1'b0));
				if (msg.is_final) begin
					fp   = ~crc_acc ^ FP_MASK;
					attr = {ATTR_TYPE, ATTR_LEN, fp};
					for (int i = 7; i >= 0; i--) begin
						expected_pkts.push_back(make_pkt(attr[8*i +: 8], i == 0));
					end
					crc_acc = CRC_INIT;
				end
			end
		end
		mismatches  <= mismatch_cnt;
		outstanding <= expected_pkts.size();
	end

endmodule

// File: test/testbench.sv
// top of the stun fingerprint appender test: clock, reset, message stimulus with random
// gaps and output stalls, verdict; depends on sfa_pkg, sfa_checker and the block itself
`timescale 1ns / 100ps

module testbench;
	import sfa_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic msg_valid;
	msg_t msg;
	logic msg_stall;
	logic pkt_valid;
	pkt_t pkt;
	logic pkt_stall;
	int   mismatches;
	int   outstanding;

	msg_t message_bytes[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stun_fingerprint_appender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg       (msg),
		.msg_stall (msg_stall),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.pkt_stall (pkt_stall)
	);

	sfa_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg_valid),
		.msg         (msg),
		.msg_stall   (msg_stall),
		.pkt_valid   (pkt_valid),
		.pkt         (pkt),
		.pkt_stall   (pkt_stall),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic void add_byte(input logic [7:0] b, input logic fin);
		msg_t m;
		m.data_byte = b;
		m.is_final  = fin;
		message_bytes.push_back(m);
	endfunction

	// random bytes, last one marked final
	function automatic void add_random_message(input int len);
		for (int i = 0; i < len; i++) begin
			add_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endfunction

	// binding-request style header, random transaction id, random attribute body
	function automatic void add_stun_message(input int body_words);
		int body_len;
		body_len = 4 * body_words;
		add_byte(8'h00, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'((body_len + 8) >> 8), 1'b0);
		add_byte(8'(body_len + 8), 1'b0);
		add_byte(8'h21, 1'b0);
		add_byte(8'h12, 1'b0);
		add_byte(8'hA4, 1'b0);
		add_byte(8'h42, 1'b0);
		for (int i = 0; i < 12 + body_len; i++) begin
			add_byte(8'($urandom_range(0, 255)), i == 11 + body_len);
		end
	endfunction

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	// output side: random stall before each transaction, with quiet stretches
	initial begin
		int  n;
		int  taken;
		bit  quiet;
		taken = 0;
		quiet = 1'b0;
		pkt_stall <= 1'b0;
		forever begin
			if (taken % 25 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			n = quiet ? 0 : $urandom_range(0, 12);
			if (n != 0) begin
				pkt_stall <= 1'b1;
				repeat (n) @(posedge clk);
				pkt_stall <= 1'b0;
			end
			do @(posedge clk); while (!pkt_valid);
			taken++;
		end
	end

	initial begin
		int  gap;
		bit  quiet;
		arst_n    <= 1'b0;
		msg_valid <= 1'b0;
		msg       <= '0;
		quiet = 1'b0;

		// single-byte messages at the start of the stream after reset
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h80, 1'b1);
		// field extremes inside a short message
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'hA5, 1'b1);
		// length field is never checked: a header claiming a huge body
		add_byte(8'h00, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h21, 1'b1);
		add_random_message(6);
		add_byte(8'h01, 1'b1);

		while (message_bytes.size() < 170) begin
			if ($urandom_range(0, 3) == 0) begin
				add_stun_message($urandom_range(0, 3));
			end else begin
				add_random_message($urandom_range(1, 16));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < message_bytes.size(); i++) begin
			if (i % 20 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			gap = quiet ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				msg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			msg_valid <= 1'b1;
			msg       <= message_bytes[i];
			do @(posedge clk); while (msg_stall);
		end
		msg_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
